// ===== rtl/core/utf8_to_utf16_transcoder_unit_defines.svh =====
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_unit_defines
// Assertion macros shared by the transcoder modules.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_TRANSCODER_UNIT_DEFINES_SVH
`define UTF8_TO_UTF16_TRANSCODER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define U8U16_ASSERT_NOW(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("u8u16 same-cycle check failed");

// next-cycle implication, checked outside reset
`define U8U16_ASSERT_NEXT(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("u8u16 next-cycle check failed");

`endif

// ===== rtl/core/u8u16_pkg.sv =====
// ----------------------------------------------------------------------------
// u8u16_pkg
// Types and constants shared by the UTF-8 to UTF-16 transcoder modules.
// ----------------------------------------------------------------------------
package u8u16_pkg;

	// result queue between decoder and output stage
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = $clog2(QDEPTH);
	localparam int unsigned QCW    = $clog2(QDEPTH + 1);

	// capacity register
	localparam logic [12:0] CAP_RESET = 13'd256;
	localparam logic [12:0] CAP_LIMIT = 13'd4096;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_ENC  = 2'd1,
		ST_CAPACITY = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_string;
	} text_item_t;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        final_unit;
		status_t     status;
		logic [11:0] unit_count;
	} unit_item_t;

	// results caused by one byte: one, or a surrogate pair
	typedef struct packed {
		logic       two;
		unit_item_t first;
		unit_item_t second;
	} unit_group_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== rtl/core/u8u16_front.sv =====
// ----------------------------------------------------------------------------
// u8u16_front
// Byte decoder: validates UTF-8, tracks per-string state and builds the
// result group for each completed character or decode error.
// ----------------------------------------------------------------------------
module u8u16_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [12:0]            cfg_wdata,
	input  logic                   push,
	input  u8u16_pkg::text_item_t  text_item,
	input  u8u16_pkg::q_stat_t     q_stat,
	output logic                   full,
	output logic                   wr_en,
	output u8u16_pkg::unit_group_t wr_data
);

	localparam logic [12:0] CAP_LIMIT_C = u8u16_pkg::CAP_LIMIT;

	logic [12:0] cap_q;
	logic [20:0] pcp_q;
	logic [1:0]  rem_q;
	logic [16:0] min_q;
	logic [11:0] cnt_q;
	logic        disc_q;

	logic [7:0]  b;
	logic        eos;
	logic        acc;
	logic        fail;
	logic        have;
	logic [20:0] cp;
	logic [20:0] cont;
	logic [20:0] pcp_d;
	logic [1:0]  rem_d;
	logic [16:0] min_d;
	logic [12:0] cap;
	logic [12:0] n1;
	logic [12:0] n2;
	logic        bmp;
	logic        cap_fail;
	logic        err;
	logic [20:0] cpm;

	assign full = q_stat.full;
	assign acc  = push && !q_stat.full;
	assign b    = text_item.text_byte;
	assign eos  = text_item.end_of_string;
	assign cont = {pcp_q[14:0], b[5:0]};

	// byte classification and sequence checks
	always_comb begin
		fail  = 1'b0;
		have  = 1'b0;
		cp    = '0;
		pcp_d = pcp_q;
		rem_d = rem_q;
		min_d = min_q;
		if (rem_q == 2'd0) begin
			if (b == 8'h00) begin
				fail = 1'b1;
			end else if (b < 8'h80) begin
				cp   = {13'd0, b};
				have = 1'b1;
			end else if (b >= 8'hC2 && b <= 8'hDF) begin
				pcp_d = {16'd0, b[4:0]};
				rem_d = 2'd1;
				min_d = 17'h00080;
			end else if (b >= 8'hE0 && b <= 8'hEF) begin
				pcp_d = {17'd0, b[3:0]};
				rem_d = 2'd2;
				min_d = 17'h00800;
			end else if (b >= 8'hF0 && b <= 8'hF4) begin
				pcp_d = {18'd0, b[2:0]};
				rem_d = 2'd3;
				min_d = 17'h10000;
			end else begin
				fail = 1'b1;
			end
		end else begin
			if (b[7:6] != 2'b10) begin
				fail = 1'b1;
			end else begin
				pcp_d = cont;
				rem_d = rem_q - 2'd1;
				if (rem_q == 2'd1) begin
					cp = cont;
					if (cont < {4'd0, min_q} || cont > 21'h10FFFF ||
							(cont >= 21'h00D800 && cont <= 21'h00DFFF)) begin
						fail = 1'b1;
					end else begin
						have = 1'b1;
					end
				end
			end
		end
		// sequence cut off by end of string
		if (!fail && !have && eos) begin
			fail = 1'b1;
		end
	end

	// capacity check, terminator slot kept free
	assign cap      = (cap_q > CAP_LIMIT_C) ? CAP_LIMIT_C : cap_q;
	assign n1       = {1'b0, cnt_q} + 13'd1;
	assign n2       = {1'b0, cnt_q} + 13'd2;
	assign bmp      = (cp[20:16] == 5'd0);
	assign cap_fail = have && (bmp ? (n1 >= cap) : (n2 >= cap));
	assign err      = fail || cap_fail;
	assign cpm      = cp - 21'h010000;

	// result group for the queue
	always_comb begin
		wr_data.two               = have && !cap_fail && !bmp;
		wr_data.second.code_unit  = {6'b110111, cpm[9:0]};
		wr_data.second.final_unit = eos;
		wr_data.second.status     = u8u16_pkg::ST_OK;
		wr_data.second.unit_count = n2[11:0];
		if (err) begin
			wr_data.first.code_unit  = 16'h0000;
			wr_data.first.final_unit = 1'b1;
			wr_data.first.status     = fail ? u8u16_pkg::ST_BAD_ENC : u8u16_pkg::ST_CAPACITY;
			wr_data.first.unit_count = cnt_q;
		end else if (bmp) begin
			wr_data.first.code_unit  = cp[15:0];
			wr_data.first.final_unit = eos;
			wr_data.first.status     = u8u16_pkg::ST_OK;
			wr_data.first.unit_count = n1[11:0];
		end else begin
			wr_data.first.code_unit  = {6'b110110, cpm[19:10]};
			wr_data.first.final_unit = 1'b0;
			wr_data.first.status     = u8u16_pkg::ST_OK;
			wr_data.first.unit_count = n1[11:0];
		end
	end

	assign wr_en = acc && !disc_q && (err || have);

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= u8u16_pkg::CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// per-string decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcp_q  <= '0;
			rem_q  <= '0;
			min_q  <= '0;
			cnt_q  <= '0;
			disc_q <= 1'b0;
		end else if (acc) begin
			if (disc_q) begin
				if (eos) begin
					disc_q <= 1'b0;
				end
			end else if (err) begin
				pcp_q  <= '0;
				rem_q  <= '0;
				min_q  <= '0;
				cnt_q  <= '0;
				disc_q <= !eos;
			end else if (have) begin
				pcp_q <= '0;
				rem_q <= '0;
				min_q <= '0;
				if (eos) begin
					cnt_q <= '0;
				end else begin
					cnt_q <= bmp ? n1[11:0] : n2[11:0];
				end
			end else begin
				pcp_q <= pcp_d;
				rem_q <= rem_d;
				min_q <= min_d;
			end
		end
	end

endmodule

// ===== rtl/core/u8u16_queue.sv =====
// ----------------------------------------------------------------------------
// u8u16_queue
// Short queue of result groups between the decoder and the output stage.
// ----------------------------------------------------------------------------
`include "utf8_to_utf16_transcoder_unit_defines.svh"

module u8u16_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  u8u16_pkg::unit_group_t wr_data,
	input  logic                   rd_en,
	output u8u16_pkg::unit_group_t rd_data,
	output u8u16_pkg::q_stat_t     stat
);

	localparam logic [u8u16_pkg::QAW-1:0] LAST = u8u16_pkg::QAW'(u8u16_pkg::QDEPTH - 1);
	localparam logic [u8u16_pkg::QCW-1:0] FULL_CNT = u8u16_pkg::QCW'(u8u16_pkg::QDEPTH);

	u8u16_pkg::unit_group_t        mem_q [u8u16_pkg::QDEPTH];
	logic [u8u16_pkg::QAW-1:0]     wp_q;
	logic [u8u16_pkg::QAW-1:0]     rp_q;
	logic [u8u16_pkg::QCW-1:0]     cnt_q;

	assign rd_data    = mem_q[rp_q];
	assign stat.full  = (cnt_q == FULL_CNT);
	assign stat.empty = (cnt_q == '0);

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wp_q <= (wp_q == LAST) ? '0 : wp_q + 1'b1;
			end
			if (rd_en) begin
				rp_q <= (rp_q == LAST) ? '0 : rp_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`U8U16_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= FULL_CNT)
	`U8U16_ASSERT_NOW(a_no_overflow, clk, arst_n, wr_en && !rd_en, !stat.full)
	`U8U16_ASSERT_NOW(a_no_underflow, clk, arst_n, rd_en, !stat.empty)
	`U8U16_ASSERT_NEXT(a_cnt_step, clk, arst_n, wr_en && !rd_en, cnt_q == $past(cnt_q) + 1'b1)

endmodule

// ===== rtl/core/u8u16_back.sv =====
// ----------------------------------------------------------------------------
// u8u16_back
// Output stage: presents the head result group one unit at a time and
// releases the group once its last unit is taken.
// ----------------------------------------------------------------------------
`include "utf8_to_utf16_transcoder_unit_defines.svh"

module u8u16_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pop,
	input  u8u16_pkg::q_stat_t     q_stat,
	input  u8u16_pkg::unit_group_t rd_data,
	output logic                   empty,
	output u8u16_pkg::unit_item_t  unit_item,
	output logic                   rd_en
);

	logic half_q;
	logic take;

	assign empty     = q_stat.empty;
	assign unit_item = half_q ? rd_data.second : rd_data.first;
	assign take      = pop && !q_stat.empty;
	assign rd_en     = take && (half_q || !rd_data.two);

	// low or high surrogate of the head pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= 1'b0;
		end else if (take) begin
			half_q <= !half_q && rd_data.two;
		end
	end

	`U8U16_ASSERT_NOW(a_half_pair, clk, arst_n, half_q, rd_data.two && !q_stat.empty)
	`U8U16_ASSERT_NEXT(a_pair_second, clk, arst_n, take && !half_q && rd_data.two, half_q)
	`U8U16_ASSERT_NEXT(a_pair_done, clk, arst_n, take && half_q, !half_q)

endmodule

// ===== rtl/core/utf8_to_utf16_transcoder_unit.sv =====
// Flow: a byte that ends a character or fails puts its result group into the queue.
// Throughput: one byte per cycle in while not full; one unit per cycle out while
// not empty; a surrogate pair leaves as two units, absorbed by the four-entry queue.
// Reset: arst_n clears decode state and empties the queue; the capacity goes to 256.
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_unit
// Strict UTF-8 to UTF-16 transcoder with queue-style input and output ports.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [12:0]           cfg_wdata,
	input  logic                  push,
	output logic                  full,
	input  u8u16_pkg::text_item_t text_item,
	output logic                  empty,
	input  logic                  pop,
	output u8u16_pkg::unit_item_t unit_item
);

	u8u16_pkg::q_stat_t     q_stat;
	u8u16_pkg::unit_group_t wr_data;
	u8u16_pkg::unit_group_t rd_data;
	logic                   wr_en;
	logic                   rd_en;

	// decoder
	u8u16_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.text_item (text_item),
		.q_stat    (q_stat),
		.full      (full),
		.wr_en     (wr_en),
		.wr_data   (wr_data)
	);

	// result queue
	u8u16_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_data (rd_data),
		.stat    (q_stat)
	);

	// output stage
	u8u16_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop       (pop),
		.q_stat    (q_stat),
		.rd_data   (rd_data),
		.empty     (empty),
		.unit_item (unit_item),
		.rd_en     (rd_en)
	);

endmodule
